// ===== sv/async_threshold_network_update_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASYNC_THRESHOLD_NETWORK_UPDATE_DEFINES_SVH
`define ASYNC_THRESHOLD_NETWORK_UPDATE_DEFINES_SVH

`ifndef SYNTH
`define ATNU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATNU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATNU_ASSERT_IMP(lbl, ante, cons)
`define ATNU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/atnu_pkg.sv =====
// ----------------------------------------------------------------------------
// atnu_pkg
// Field widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package atnu_pkg;

  localparam int NODE_W    = 6;
  localparam int VALUE_W   = 8;
  localparam int CFG_W     = 7;
  localparam int SUM_OUT_W = 14;
  localparam int SUM_MAX   = 8191;
  localparam int SUM_MIN   = -8192;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SET    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic start_sum;
    logic issue;
    logic finish;
  } atnu_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_update;
    logic sum_issued;
    logic out_free;
  } atnu_sts_t;

endpackage

// ===== sv/atnu_ctrl.sv =====
// ----------------------------------------------------------------------------
// atnu_ctrl
// Sequencer: accept a beat, run the row sum when needed, hand off the result.
// ----------------------------------------------------------------------------
`include "async_threshold_network_update_defines.svh"

module atnu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  atnu_pkg::atnu_sts_t   sts,
  output atnu_pkg::atnu_cmd_t   cmd
);

  atnu_pkg::ctrl_state_t state;
  atnu_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atnu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atnu_pkg::S_IDLE: begin
        if (in_valid) state_next = atnu_pkg::S_EXEC;
      end
      atnu_pkg::S_EXEC: begin
        if (!sts.bad && sts.is_update) state_next = atnu_pkg::S_SUM;
        else state_next = atnu_pkg::S_DONE;
      end
      atnu_pkg::S_SUM: begin
        if (sts.sum_issued) state_next = atnu_pkg::S_DONE;
      end
      atnu_pkg::S_DONE: begin
        if (sts.out_free) state_next = atnu_pkg::S_IDLE;
      end
      default: state_next = atnu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == atnu_pkg::S_IDLE);
    cmd.load_item = (state == atnu_pkg::S_IDLE) && in_valid;
    cmd.start_sum = (state == atnu_pkg::S_EXEC) && !sts.bad && sts.is_update;
    cmd.issue     = (state == atnu_pkg::S_SUM) && !sts.sum_issued;
    cmd.finish    = (state == atnu_pkg::S_DONE) && sts.out_free;
  end

  `ATNU_ASSERT_IMP(a_issue_bounded, cmd.issue, !sts.sum_issued)
  `ATNU_ASSERT_IMP(a_finish_free, cmd.finish, sts.out_free)
  `ATNU_ASSERT_NXT(a_load_then_exec, cmd.load_item, state == atnu_pkg::S_EXEC)
  `ATNU_ASSERT_NXT(a_sum_not_bad, cmd.start_sum, state == atnu_pkg::S_SUM)

endmodule

// ===== sv/atnu_datapath.sv =====
// ----------------------------------------------------------------------------
// atnu_datapath
// Item registers, node states, weight memory, row accumulator, output beat.
// ----------------------------------------------------------------------------
module atnu_datapath #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [23:0]                   s_tdata,
  input  logic [1:0]                    s_tuser,
  input  logic                          cfg_we,
  input  logic [atnu_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,
  input  atnu_pkg::atnu_cmd_t           cmd,
  output atnu_pkg::atnu_sts_t           sts
);

  localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CNT_W   = ($clog2(MAX_NODES + 1) > atnu_pkg::CFG_W) ?
                           $clog2(MAX_NODES + 1) : atnu_pkg::CFG_W;
  localparam int ROWX_W  = (IDX_W > atnu_pkg::NODE_W) ? IDX_W : atnu_pkg::NODE_W;
  localparam int WX_W    = (WEIGHT_BITS > atnu_pkg::VALUE_W) ?
                           WEIGHT_BITS : atnu_pkg::VALUE_W;
  localparam int SUM_W   = WEIGHT_BITS + CNT_W + 1;
  localparam int EXT_W   = (SUM_W > atnu_pkg::SUM_OUT_W) ? SUM_W : atnu_pkg::SUM_OUT_W + 1;

  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(atnu_pkg::SUM_MAX);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(atnu_pkg::SUM_MIN);
  localparam logic [CNT_W-1:0]        MAX_CNT = CNT_W'(MAX_NODES);

  atnu_pkg::action_t                   act_q;
  logic [atnu_pkg::NODE_W-1:0]         row_q;
  logic [atnu_pkg::NODE_W-1:0]         col_q;
  logic signed [atnu_pkg::VALUE_W-1:0] val_q;

  logic [atnu_pkg::CFG_W-1:0] node_count;
  logic [MAX_NODES-1:0]       node_states;
  logic [WEIGHT_BITS-1:0]     weights [DEPTH];

  logic [CNT_W-1:0]              j;
  logic                          rd_vld;
  logic                          rd_on;
  logic signed [WEIGHT_BITS-1:0] rdata_q;
  logic signed [SUM_W-1:0]       acc;

  logic [CNT_W-1:0]          cnt_eff;
  logic [CNT_W-1:0]          cnt_cfg;
  logic [ROWX_W-1:0]         row_x;
  logic [ROWX_W-1:0]         col_x;
  logic [IDX_W-1:0]          row_i;
  logic [IDX_W-1:0]          col_i;
  logic [IDX_W-1:0]          j_i;
  logic                      bad;
  logic signed [WX_W-1:0]    val_x;
  logic [WEIGHT_BITS-1:0]    wval;
  logic                      old_st;
  logic                      new_st;
  logic signed [EXT_W-1:0]   sum_x;
  logic [atnu_pkg::SUM_OUT_W-1:0] sum_sat;

  logic                               res_state;
  logic [atnu_pkg::SUM_OUT_W-1:0]     res_sum;
  logic                               res_changed;

  logic                               o_state;
  logic [atnu_pkg::SUM_OUT_W-1:0]     o_sum;
  logic                               o_changed;
  logic                               o_bad;

  always_comb begin
    cnt_cfg = CNT_W'(node_count);
    cnt_eff = (cnt_cfg < MAX_CNT) ? cnt_cfg : MAX_CNT;
    row_x   = ROWX_W'(row_q);
    col_x   = ROWX_W'(col_q);
    row_i   = row_x[IDX_W-1:0];
    col_i   = col_x[IDX_W-1:0];
    j_i     = j[IDX_W-1:0];
    bad     = (CNT_W'(row_q) >= cnt_eff) ||
              ((act_q == atnu_pkg::ACT_WRITE) && (CNT_W'(col_q) >= cnt_eff));
    val_x   = WX_W'(val_q);
    wval    = val_x[WEIGHT_BITS-1:0];
    old_st  = bad ? 1'b0 : node_states[row_i];
    if (acc == '0) new_st = old_st;
    else new_st = !acc[SUM_W-1];
    sum_x   = EXT_W'(acc);
    if (sum_x > SAT_HI) sum_x = SAT_HI;
    else if (sum_x < SAT_LO) sum_x = SAT_LO;
    sum_sat = sum_x[atnu_pkg::SUM_OUT_W-1:0];
  end

  always_comb begin
    res_state   = 1'b0;
    res_sum     = '0;
    res_changed = 1'b0;
    if (!bad) begin
      unique case (act_q)
        atnu_pkg::ACT_WRITE:  res_state = old_st;
        atnu_pkg::ACT_SET:    res_state = val_q[0];
        atnu_pkg::ACT_UPDATE: begin
          res_state   = new_st;
          res_sum     = sum_sat;
          res_changed = (new_st != old_st);
        end
        atnu_pkg::ACT_READ:   res_state = old_st;
        default:              res_state = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_q <= atnu_pkg::action_t'(s_tuser);
      row_q <= s_tdata[5:0];
      col_q <= s_tdata[11:6];
      val_q <= s_tdata[19:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= atnu_pkg::NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_states <= '0;
    end else if (cmd.finish && !bad) begin
      if (act_q == atnu_pkg::ACT_SET) node_states[row_i] <= val_q[0];
      else if (act_q == atnu_pkg::ACT_UPDATE) node_states[row_i] <= new_st;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !bad && (act_q == atnu_pkg::ACT_WRITE)) begin
      weights[{row_i, col_i}] <= wval;
    end
    if (cmd.issue) begin
      rdata_q <= weights[{row_i, j_i}];
      rd_on   <= node_states[j_i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j      <= '0;
      rd_vld <= 1'b0;
      acc    <= '0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.start_sum) begin
        j   <= '0;
        acc <= '0;
      end else begin
        if (cmd.issue) j <= j + 1'b1;
        if (rd_vld && rd_on) acc <= acc + SUM_W'(rdata_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_state   <= res_state;
      o_sum     <= res_sum;
      o_changed <= res_changed;
      o_bad     <= bad;
    end
  end

  assign m_tdata = {7'd0, o_bad, o_changed, o_sum, o_state};

  always_comb begin
    sts.bad        = bad;
    sts.is_update  = (act_q == atnu_pkg::ACT_UPDATE);
    sts.sum_issued = (j == cnt_eff);
    sts.out_free   = !m_tvalid || m_tready;
  end

endmodule

// ===== sv/async_threshold_network_update.sv =====
// ----------------------------------------------------------------------------
// async_threshold_network_update
// Threshold network of one-bit nodes with a signed weight matrix.
// ----------------------------------------------------------------------------
// One result beat per input beat. A weight write, node set, node read or any
// beat with a bad index goes from acceptance through S_EXEC and S_DONE to the
// output register; a node update also passes S_SUM, where the single weight
// memory read port feeds one accumulator, one column per cycle. The next beat
// is taken the cycle after a result is loaded, even while that result waits on
// m_tready. The weight memory has no clearing pass: read only written entries.
module async_threshold_network_update #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [23:0]                s_tdata,   // node[5:0], column[11:6], value[19:12]
  input  logic [1:0]                 s_tuser,   // action[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,   // node_state[0], weighted_sum[14:1],
                                                // changed[15], bad_index[16]
  input  logic                       cfg_we,
  input  logic [atnu_pkg::CFG_W-1:0] cfg_wdata  // node_count
);

  atnu_pkg::atnu_cmd_t cmd;
  atnu_pkg::atnu_sts_t sts;

  atnu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atnu_datapath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== test/tb_async_threshold_network_update.sv =====
// ----------------------------------------------------------------------------
// tb_async_threshold_network_update
// Stream-level test of the threshold network: weight writes, node sets,
// reads and updates are driven as input beats. Each beat is predicted by an
// internal network model and every result beat is checked field by field,
// under several node counts, random idling on both sides and a long output
// stall.
// ----------------------------------------------------------------------------
module tb_async_threshold_network_update;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES      = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic              bad;
    logic              changed;
    logic signed [13:0] sum;
    logic              state;
  } net_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [23:0]         s_tdata;   // node[5:0], column[11:6], value[19:12]
  logic [1:0]          s_tuser;   // action[1:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;   // node_state[0], weighted_sum[14:1],
                                  // changed[15], bad_index[16]
  logic                cfg_we;
  logic [atnu_pkg::CFG_W-1:0] cfg_wdata;

  logic               node_bits [NODES];
  logic signed [7:0]  weights [NODES][NODES];
  bit                 weight_written [NODES][NODES];
  int                 node_count_q = int'(atnu_pkg::NODE_COUNT_RESET);

  net_result_t pending_results[$];
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          updates_sent = 0;
  int          results_checked = 0;
  int          quiet_cycles = 0;
  bit          idle_en = 1'b1;
  bit          hold_off_req = 1'b0;

  async_threshold_network_update u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int active_nodes();
    return (node_count_q > NODES) ? NODES : node_count_q;
  endfunction

  function automatic net_result_t apply_action(atnu_pkg::action_t act, logic [5:0] row,
                                               logic [5:0] col, logic [7:0] val);
    net_result_t r;
    int          cnt;
    int          sum;
    logic        prev;
    logic        next;
    r   = '0;
    sum = 0;
    cnt = active_nodes();
    if (row >= cnt || (act == atnu_pkg::ACT_WRITE && col >= cnt)) begin
      r.bad = 1'b1;
    end else begin
      case (act)
        atnu_pkg::ACT_WRITE: begin
          weights[row][col]        = val;
          weight_written[row][col] = 1'b1;
          r.state                  = node_bits[row];
        end
        atnu_pkg::ACT_SET: begin
          node_bits[row] = val[0];
          r.state        = val[0];
        end
        atnu_pkg::ACT_UPDATE: begin
          prev = node_bits[row];
          for (int j = 0; j < cnt; j++) begin
            if (node_bits[j]) sum += int'(weights[row][j]);
          end
          next           = (sum > 0) ? 1'b1 : ((sum < 0) ? 1'b0 : prev);
          node_bits[row] = next;
          r.state        = next;
          r.changed      = (next != prev);
        end
        default: begin
          r.state = node_bits[row];
        end
      endcase
    end
    if (sum > atnu_pkg::SUM_MAX) sum = atnu_pkg::SUM_MAX;
    if (sum < atnu_pkg::SUM_MIN) sum = atnu_pkg::SUM_MIN;
    r.sum = sum[13:0];
    return r;
  endfunction

  task automatic send_beat(atnu_pkg::action_t act, int row, int col, logic [7:0] val);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, val, col[5:0], row[5:0]};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_action(act, row[5:0], col[5:0], val));
    beats_sent++;
    if (act == atnu_pkg::ACT_UPDATE) updates_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_node_count(int count);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count[atnu_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    node_count_q = count;
  endtask

  task automatic send_random_beat();
    int                cnt;
    int                pick;
    int                row;
    int                col;
    int                hot;
    int                gap;
    atnu_pkg::action_t act;
    logic [7:0]        val;
    cnt  = active_nodes();
    pick = $urandom_range(0, 99);
    act  = (pick < 30) ? atnu_pkg::ACT_WRITE : (pick < 50) ? atnu_pkg::ACT_SET :
           (pick < 85) ? atnu_pkg::ACT_UPDATE : atnu_pkg::ACT_READ;
    val  = 8'($urandom_range(0, 255));
    hot  = (cnt < 4) ? cnt : 4;
    col  = (cnt > 0 && $urandom_range(0, 6) != 0) ? $urandom_range(0, cnt - 1)
                                                  : $urandom_range(0, 63);
    if (cnt == 0 || $urandom_range(0, 6) == 0)
      row = $urandom_range(0, 63);
    else if (act == atnu_pkg::ACT_UPDATE && $urandom_range(0, 3) != 0)
      row = $urandom_range(0, hot - 1);
    else
      row = $urandom_range(0, cnt - 1);
    // fill the row before any update reads it
    if (act == atnu_pkg::ACT_UPDATE && row < cnt) begin
      gap = -1;
      for (int j = cnt - 1; j >= 0; j--) begin
        if (!weight_written[row][j]) gap = j;
      end
      if (gap >= 0) begin
        act = atnu_pkg::ACT_WRITE;
        col = gap;
      end
    end
    send_beat(act, row, col, val);
  endtask

  task automatic test_directed_cases();
    write_node_count(2);
    send_beat(atnu_pkg::ACT_READ,   0, 0, 8'h00);
    send_beat(atnu_pkg::ACT_WRITE,  0, 0, 8'h7F);
    send_beat(atnu_pkg::ACT_WRITE,  0, 1, 8'h80);
    send_beat(atnu_pkg::ACT_WRITE,  1, 0, 8'hFF);
    send_beat(atnu_pkg::ACT_WRITE,  1, 1, 8'h01);
    send_beat(atnu_pkg::ACT_SET,    0, 0, 8'h81);
    send_beat(atnu_pkg::ACT_SET,    1, 0, 8'hFE);
    send_beat(atnu_pkg::ACT_UPDATE, 0, 0, 8'h00);
    send_beat(atnu_pkg::ACT_UPDATE, 1, 0, 8'h00);
    send_beat(atnu_pkg::ACT_SET,    1, 0, 8'h01);
    send_beat(atnu_pkg::ACT_UPDATE, 1, 0, 8'h00);
    send_beat(atnu_pkg::ACT_UPDATE, 0, 63, 8'hFF);
    send_beat(atnu_pkg::ACT_READ,   1, 0, 8'h00);
    send_beat(atnu_pkg::ACT_READ,   2, 0, 8'h00);
    send_beat(atnu_pkg::ACT_WRITE,  0, 2, 8'h55);
    send_beat(atnu_pkg::ACT_WRITE,  63, 63, 8'h80);
    send_beat(atnu_pkg::ACT_UPDATE, 63, 0, 8'h00);
    send_beat(atnu_pkg::ACT_SET,    5, 0, 8'h01);
    write_node_count(0);
    send_beat(atnu_pkg::ACT_READ,   0, 0, 8'h00);
    send_beat(atnu_pkg::ACT_UPDATE, 0, 0, 8'h00);
    write_node_count(127);
    send_beat(atnu_pkg::ACT_READ,   63, 0, 8'h00);
    send_beat(atnu_pkg::ACT_SET,    63, 0, 8'hFF);
    send_beat(atnu_pkg::ACT_READ,   63, 0, 8'h00);
    send_beat(atnu_pkg::ACT_WRITE,  63, 63, 8'h7F);
  endtask

  task automatic test_extreme_sums();
    write_node_count(64);
    for (int j = 0; j < NODES; j++) send_beat(atnu_pkg::ACT_WRITE, 0, j, 8'h7F);
    for (int j = 0; j < NODES; j++) send_beat(atnu_pkg::ACT_WRITE, 1, j, 8'h80);
    for (int j = 0; j < NODES; j++) send_beat(atnu_pkg::ACT_SET, j, 0, 8'h01);
    send_beat(atnu_pkg::ACT_UPDATE, 0, 0, 8'h00);
    send_beat(atnu_pkg::ACT_UPDATE, 1, 0, 8'h00);
    send_beat(atnu_pkg::ACT_READ,   1, 0, 8'h00);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    hold_off_req = 1'b1;
    repeat (12) send_random_beat();
  endtask

  task automatic test_random_mix(int count, int beats, bit with_idle);
    write_node_count(count);
    idle_en = with_idle;
    repeat (beats) send_random_beat();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < NODES; i++) node_bits[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_extreme_sums();
    test_output_backpressure();
    test_random_mix(8, 300, 1'b1);
    test_random_mix(64, 300, 1'b1);
    test_random_mix(1, 60, 1'b1);
    test_random_mix(0, 30, 1'b1);
    test_random_mix(127, 120, 1'b1);
    test_random_mix(37, 150, 1'b0);

    wait_idle();
    repeat (80) @(posedge clk);
    $display("Sent %0d beats (%0d updates), checked %0d results", beats_sent,
             updates_sent, results_checked);
    $display("Node counts 0, 1, 2, 8, 37, 64 and 127; full-scale sums; output stall");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    net_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expected result, tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[0] !== exp_r.state) begin
          $error("node_state expected %0d actual %0d", exp_r.state, m_tdata[0]);
          mismatch_count++;
        end
        if (m_tdata[14:1] !== exp_r.sum) begin
          $error("weighted_sum expected %0d actual %0d", exp_r.sum,
                 $signed(m_tdata[14:1]));
          mismatch_count++;
        end
        if (m_tdata[15] !== exp_r.changed) begin
          $error("changed expected %0d actual %0d", exp_r.changed, m_tdata[15]);
          mismatch_count++;
        end
        if (m_tdata[16] !== exp_r.bad) begin
          $error("bad_index expected %0d actual %0d", exp_r.bad, m_tdata[16]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
